### rtl/decimal_seven_segment_scan_core_macros.svh
// assertion helpers used by the checker file
`ifndef DECIMAL_SEVEN_SEGMENT_SCAN_CORE_MACROS_SVH
`define DECIMAL_SEVEN_SEGMENT_SCAN_CORE_MACROS_SVH

// same-cycle implication
`define DSS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dss assertion failed");

// next-cycle implication
`define DSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dss assertion failed");

`endif

### rtl/dss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dss_pkg;

   localparam int QueueDepth   = 4;
   localparam int ValueWidth   = 16;
   localparam int DigitWidth   = 4;
   localparam int BcdDigits    = 5;
   localparam int BcdWidth     = BcdDigits * DigitWidth;
   localparam int BitsPerStage = 2;
   localparam int DabbleStages = ValueWidth / BitsPerStage;

   localparam logic [ValueWidth-1:0] SatLimit = 16'd9999;
   localparam logic [7:0]            SegBlank = 8'h00;

   typedef enum logic [1:0] {
      MODE_LEFT  = 2'd0,
      MODE_RIGHT = 2'd1,
      MODE_ALL   = 2'd2
   } mode_type;

   typedef struct packed {
      logic [1:0]            mode;
      logic [ValueWidth-1:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0] digit_enable_n;
      logic [7:0] segments_n;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]          mode;
      logic [BcdWidth-1:0] bcd;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } job_msg_type;

   function automatic logic [7:0] seg_pattern(input logic [DigitWidth-1:0] digit);
      logic [7:0] pattern;
      case (digit)
         4'd0:    pattern = 8'h3F;
         4'd1:    pattern = 8'h06;
         4'd2:    pattern = 8'h5B;
         4'd3:    pattern = 8'h4F;
         4'd4:    pattern = 8'h66;
         4'd5:    pattern = 8'h6D;
         4'd6:    pattern = 8'h7D;
         4'd7:    pattern = 8'h07;
         4'd8:    pattern = 8'h7F;
         4'd9:    pattern = 8'h6F;
         default: pattern = SegBlank;
      endcase
      return pattern;
   endfunction

   // one shift-and-add-3 step
   function automatic logic [BcdWidth-1:0] dabble_step(input logic [BcdWidth-1:0] bcd,
                                                       input logic bit_in);
      logic [BcdWidth-1:0]   adj;
      logic [DigitWidth-1:0] d;
      for (int i = 0; i < BcdDigits; i++) begin
         d = bcd[i*DigitWidth +: DigitWidth];
         adj[i*DigitWidth +: DigitWidth] = (d >= 4'd5) ? d + 4'd3 : d;
      end
      return {adj[BcdWidth-2:0], bit_in};
   endfunction

endpackage

`default_nettype wire

### rtl/dss_front.sv
`timescale 1ns / 1ps
`default_nettype none

module dss_front #(
   parameter int QUEUE_DEPTH = dss_pkg::QueueDepth
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire dss_pkg::req_type      req_payload,
   input  wire logic                  credit_return,
   output dss_pkg::job_msg_type       push_msg
);

   localparam int CntW   = $clog2(QUEUE_DEPTH + 1);
   localparam int Stages = dss_pkg::DabbleStages;
   localparam int VW     = dss_pkg::ValueWidth;
   localparam int BW     = dss_pkg::BcdWidth;

   logic [CntW-1:0] credit_cnt_ff, credit_cnt_in;
   logic            accept, mode_ok, take;
   logic [VW-1:0]   value_sat;

   logic            stage_valid_ff [0:Stages];
   logic            stage_valid_in [0:Stages];
   logic [1:0]      stage_mode_ff  [0:Stages];
   logic [1:0]      stage_mode_in  [0:Stages];
   logic [BW-1:0]   stage_bcd_ff   [0:Stages];
   logic [BW-1:0]   stage_bcd_in   [0:Stages];
   logic [VW-1:0]   stage_bin_ff   [0:Stages];
   logic [VW-1:0]   stage_bin_in   [0:Stages];
   logic [BW-1:0]   bcd_mid        [1:Stages];

   assign req_full = (credit_cnt_ff == CntW'(QUEUE_DEPTH));
   assign accept   = req_push && !req_full;
   assign mode_ok  = (req_payload.mode == dss_pkg::MODE_LEFT)  ||
                     (req_payload.mode == dss_pkg::MODE_RIGHT) ||
                     (req_payload.mode == dss_pkg::MODE_ALL);
   assign take     = accept && mode_ok;

   // four-digit modes saturate
   always_comb begin
      value_sat = req_payload.value;
      if ((req_payload.mode != dss_pkg::MODE_ALL) && (req_payload.value > dss_pkg::SatLimit)) begin
         value_sat = dss_pkg::SatLimit;
      end
   end

   assign credit_cnt_in = credit_cnt_ff + CntW'(take) - CntW'(credit_return);

   always_comb begin
      stage_valid_in[0] = take;
      stage_mode_in[0]  = req_payload.mode;
      stage_bcd_in[0]   = '0;
      stage_bin_in[0]   = value_sat;
      for (int k = 1; k <= Stages; k++) begin
         bcd_mid[k]        = dss_pkg::dabble_step(stage_bcd_ff[k-1], stage_bin_ff[k-1][VW-1]);
         stage_valid_in[k] = stage_valid_ff[k-1];
         stage_mode_in[k]  = stage_mode_ff[k-1];
         stage_bcd_in[k]   = dss_pkg::dabble_step(bcd_mid[k], stage_bin_ff[k-1][VW-2]);
         stage_bin_in[k]   = {stage_bin_ff[k-1][VW-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_cnt_ff <= '0;
         for (int k = 0; k <= Stages; k++) begin
            stage_valid_ff[k] <= 1'b0;
         end
      end else begin
         credit_cnt_ff <= credit_cnt_in;
         for (int k = 0; k <= Stages; k++) begin
            stage_valid_ff[k] <= stage_valid_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= Stages; k++) begin
         stage_mode_ff[k] <= stage_mode_in[k];
         stage_bcd_ff[k]  <= stage_bcd_in[k];
         stage_bin_ff[k]  <= stage_bin_in[k];
      end
   end

   assign push_msg.valid    = stage_valid_ff[Stages];
   assign push_msg.job.mode = stage_mode_ff[Stages];
   assign push_msg.job.bcd  = stage_bcd_ff[Stages];

endmodule

`default_nettype wire

### rtl/dss_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module dss_queue #(
   parameter int QUEUE_DEPTH = dss_pkg::QueueDepth
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dss_pkg::job_msg_type  push_msg,
   input  wire logic                  pop,
   output dss_pkg::job_msg_type       head
);

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   dss_pkg::job_type entries_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_msg.valid) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      count_in = count_ff + CntW'(push_msg.valid) - CntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_msg.valid) begin
         entries_ff[wr_ptr_ff] <= push_msg.job;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.job   = entries_ff[rd_ptr_ff];

endmodule

`default_nettype wire

### rtl/dss_back.sv
`timescale 1ns / 1ps
`default_nettype none

module dss_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dss_pkg::job_msg_type  head,
   output logic                       pop,
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output dss_pkg::rsp_type           rsp_payload
);

   localparam int BW = dss_pkg::BcdWidth;
   localparam int DW = dss_pkg::DigitWidth;

   logic            busy_ff, busy_in;
   logic [1:0]      mode_ff, mode_in;
   logic [BW-1:0]   bcd_ff, bcd_in;
   logic [2:0]      step_ff, step_in;
   logic            leading_ff, leading_in;
   logic            out_valid_ff, out_valid_in;
   dss_pkg::rsp_type out_data_ff, out_data_in;

   logic            advance, emit, load, last_step, blank;
   logic [2:0]      digit_idx, pos;
   logic [8*DW-1:0] bcd_wide;
   logic [DW-1:0]   digit;
   logic [7:0]      pattern;

   assign advance   = !out_valid_ff || rsp_pop;
   assign emit      = busy_ff && advance;
   assign last_step = (mode_ff == dss_pkg::MODE_ALL) ? (step_ff == 3'd7) : (step_ff == 3'd3);
   assign load      = head.valid && (!busy_ff || (emit && last_step));
   assign pop       = load;

   // digit index counts from the right, position from the left
   assign digit_idx = ((mode_ff == dss_pkg::MODE_ALL) ? 3'd7 : 3'd3) - step_ff;
   assign pos       = ((mode_ff == dss_pkg::MODE_RIGHT) ? 3'd4 : 3'd0) + step_ff;
   assign bcd_wide  = {(8*DW - BW)'(0), bcd_ff};
   assign digit     = bcd_wide[digit_idx*DW +: DW];
   assign blank     = leading_ff && (digit == '0) && !last_step;
   assign pattern   = blank ? dss_pkg::SegBlank : dss_pkg::seg_pattern(digit);

   always_comb begin
      busy_in    = busy_ff;
      mode_in    = mode_ff;
      bcd_in     = bcd_ff;
      step_in    = step_ff;
      leading_in = leading_ff;
      if (load) begin
         busy_in    = 1'b1;
         mode_in    = head.job.mode;
         bcd_in     = head.job.bcd;
         step_in    = '0;
         leading_in = 1'b1;
      end else if (emit) begin
         if (last_step) begin
            busy_in = 1'b0;
         end
         step_in    = step_ff + 3'd1;
         leading_in = leading_ff && (digit == '0);
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance) begin
         out_valid_in               = emit;
         out_data_in.digit_enable_n = ~(8'h80 >> pos);
         out_data_in.segments_n     = ~pattern;
         out_data_in.last           = last_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      bcd_ff      <= bcd_in;
      step_ff     <= step_in;
      leading_ff  <= leading_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_empty   = !out_valid_ff;
   assign rsp_payload = out_data_ff;

endmodule

`default_nettype wire

### rtl/decimal_seven_segment_scan_core.sv
// Decimal seven-segment scan core.
// Request queue side: drive req_payload (mode, value) with req_push; a transaction
// is taken on a clock edge with req_push high and req_full low. Mode 0 scans the left
// four digits, mode 1 the right four, mode 2 all eight; mode 3 is taken and dropped.
// Response queue side: while rsp_empty is low the oldest scan step sits on rsp_payload
// (active-low digit enable, active-low segments, last flag) and leaves on an edge with
// rsp_pop high. A request gives 4 steps in modes 0 and 1 and 8 in mode 2.
// A taken request passes an input register, the conversion stages and the job queue
// before the idle scanner shows its first step. The binary to decimal conversion is
// an 8-stage pipeline, two bits per stage, feeding a job queue of QUEUE_DEPTH entries;
// the scanner issues one step per cycle unless stalled, loading the next job on a last step.
// req_full rises once QUEUE_DEPTH requests are in conversion or queued.
// A stalled response holds its step; the scanner and then the queue and the request
// side back up behind it. Reset empties every stage, the queue and the output register.
`timescale 1ns / 1ps
`default_nettype none

module decimal_seven_segment_scan_core #(
   parameter int QUEUE_DEPTH = dss_pkg::QueueDepth
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire dss_pkg::req_type  req_payload,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output dss_pkg::rsp_type       rsp_payload
);

   dss_pkg::job_msg_type push_msg;
   dss_pkg::job_msg_type head;
   logic                 job_pop;

   dss_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_payload   (req_payload),
      .credit_return (job_pop),
      .push_msg      (push_msg)
   );

   dss_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_msg (push_msg),
      .pop      (job_pop),
      .head     (head)
   );

   dss_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .pop         (job_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

### rtl/dss_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "decimal_seven_segment_scan_core_macros.svh"

module dss_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_full,
   input wire logic              rsp_empty,
   input wire logic              rsp_pop,
   input wire dss_pkg::rsp_type  rsp_payload
);

   `DSS_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, (rsp_empty && !req_full))

   `DSS_ASSERT_NEXT(a_stall_holds, clock, reset, (!rsp_empty && !rsp_pop), (!rsp_empty && $stable(rsp_payload)))

   `DSS_ASSERT_IMPL(a_one_digit, clock, reset, !rsp_empty, $onehot(~rsp_payload.digit_enable_n))

   `DSS_ASSERT_IMPL(a_last_shown, clock, reset, (!rsp_empty && rsp_payload.last), ((rsp_payload.segments_n != 8'hFF) && (rsp_payload.digit_enable_n == 8'hEF || rsp_payload.digit_enable_n == 8'hFE)))

   `DSS_ASSERT_NEXT(a_scan_moves, clock, reset, (!rsp_empty && rsp_pop && !rsp_payload.last), (!rsp_empty && (rsp_payload.digit_enable_n == {1'b1, $past(rsp_payload.digit_enable_n[7:1])})))

endmodule

bind decimal_seven_segment_scan_core dss_checker u_checker (.*);

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import dss_pkg::*;

   // mode code that the block takes and drops
   localparam logic [1:0] MODE_NONE = 2'd3;
   localparam int unsigned FOUR_DIGIT_MAX = 9999;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_payload = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_payload;

   req_type     pending_reqs[$];
   rsp_type     scan_expect[$];
   int unsigned send_idle_pct = 6;
   int unsigned recv_idle_pct = 86;
   logic        hold_rsp = 1'b0;
   logic        req_taken = 1'b0;
   int unsigned n_queued = 0;
   int unsigned n_taken = 0;
   int unsigned n_errors = 0;

   decimal_seven_segment_scan_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_payload (req_payload),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $time, what);
      n_errors++;
   endtask

   function automatic logic [7:0] digit_segments(input int unsigned digit);
      case (digit)
         0: return 8'h3F;
         1: return 8'h06;
         2: return 8'h5B;
         3: return 8'h4F;
         4: return 8'h66;
         5: return 8'h6D;
         6: return 8'h7D;
         7: return 8'h07;
         8: return 8'h7F;
         default: return 8'h6F;
      endcase
   endfunction

   // builds the scan steps one request should produce
   function automatic void predict_scan(input req_type rq);
      int unsigned digits[8];
      logic [7:0]  pattern;
      int unsigned num;
      int          count;
      int          first_pos;
      bit          blanking;
      rsp_type     step;
      if (rq.mode == MODE_NONE) return;
      num = rq.value;
      if (rq.mode == MODE_ALL) begin
         count = 8;
         first_pos = 1;
      end else begin
         count = 4;
         first_pos = (rq.mode == MODE_LEFT) ? 1 : 5;
         if (num > FOUR_DIGIT_MAX) num = FOUR_DIGIT_MAX;
      end
      for (int i = count - 1; i >= 0; i--) begin
         digits[i] = num % 10;
         num = num / 10;
      end
      // leading zero blanking; the last position is always lit
      blanking = 1'b1;
      for (int i = 0; i < count; i++) begin
         blanking = blanking && (i < count - 1) && (digits[i] == 0);
         pattern = blanking ? 8'h00 : digit_segments(digits[i]);
         step.digit_enable_n = ~(8'h80 >> (first_pos + i - 1));
         step.segments_n = ~pattern;
         step.last = (i == count - 1);
         scan_expect.push_back(step);
      end
   endfunction

   task automatic add_req(input logic [1:0] mode, input logic [15:0] value);
      req_type rq;
      rq.mode = mode;
      rq.value = value;
      pending_reqs.push_back(rq);
      n_queued++;
   endtask

   task automatic add_random_reqs(input int count);
      logic [1:0]  mode;
      logic [15:0] value;
      for (int k = 0; k < count; k++) begin
         mode = ($urandom_range(19) == 0) ? MODE_NONE : 2'($urandom_range(2));
         case ($urandom_range(3))
            0: value = 16'($urandom_range(65535));
            1: value = 16'($urandom_range(99));
            2: value = 16'($urandom_range(10010, 9990));
            default: value = 16'($urandom_range(9999));
         endcase
         add_req(mode, value);
      end
   endtask

   task automatic wait_drained();
      while (n_taken != n_queued || scan_expect.size() != 0) @(negedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (!req_push || req_taken) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_payload <= pending_reqs.pop_front();
            req_push <= 1'b1;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // response side pop
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor: predicts on each request transaction, checks each response transaction
   always @(posedge clock) begin
      rsp_type want;
      req_taken <= !reset && req_push && !req_full;
      if (!reset && req_push && !req_full) begin
         predict_scan(req_payload);
         n_taken <= n_taken + 1;
      end
      if (!reset && rsp_pop && !rsp_empty) begin
         if (scan_expect.size() == 0) begin
            report_mismatch($sformatf("unexpected response %h", rsp_payload));
         end else begin
            want = scan_expect.pop_front();
            if (rsp_payload.digit_enable_n !== want.digit_enable_n)
               report_mismatch($sformatf("digit_enable_n %h, want %h",
                                         rsp_payload.digit_enable_n, want.digit_enable_n));
            if (rsp_payload.segments_n !== want.segments_n)
               report_mismatch($sformatf("segments_n %h, want %h",
                                         rsp_payload.segments_n, want.segments_n));
            if (rsp_payload.last !== want.last)
               report_mismatch($sformatf("last %b, want %b", rsp_payload.last, want.last));
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field extremes, saturation, blanking across halves, dropped mode
      for (int m = 0; m < 3; m++) begin
         add_req(2'(m), 16'd0);
         add_req(2'(m), 16'd9);
         add_req(2'(m), 16'd10);
         add_req(2'(m), 16'd9999);
         add_req(2'(m), 16'd10000);
         add_req(2'(m), 16'hFFFF);
      end
      add_req(MODE_ALL, 16'd100);
      add_req(MODE_ALL, 16'd1000);
      add_req(MODE_LEFT, 16'd1234);
      add_req(MODE_RIGHT, 16'd505);
      add_req(MODE_NONE, 16'd0);
      add_req(MODE_NONE, 16'hFFFF);
      add_random_reqs(110);
      wait_drained();

      @(posedge clock);
      send_idle_pct = 86;
      recv_idle_pct = 6;
      add_random_reqs(110);
      wait_drained();

      // long response stall while requests keep coming
      @(posedge clock);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random_reqs(40);
      hold_rsp = 1'b1;
      repeat (200) @(posedge clock);
      hold_rsp = 1'b0;
      wait_drained();

      add_random_reqs(96);
      wait_drained();
      repeat (40) @(negedge clock);
      if (n_errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
